@@ hw/rtl/pptcs_pkg.sv @@
// shared types, constants and helpers for the ping-pong chunk transfer sequencer
`default_nettype none

package pptcs_pkg;

    // largest chunk moved by one request
    localparam int unsigned CHUNK_BYTES = 65536;

    // file sizes saturate here
    localparam int unsigned MAX_FILE = 2 ** 24;

    localparam int unsigned SIZE_W  = 25;
    localparam int unsigned OFF_W   = 24;
    localparam int unsigned LEN_W   = 17;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned KIND_W  = 2;

    // result queue
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // stream and register port widths
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 72;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_START     = 2'd0,
        CMD_DISC_DONE = 2'd1,
        CMD_AUX_DONE  = 2'd2,
        CMD_POLL      = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS = 2'd0,
        KIND_AUX    = 2'd1,
        KIND_DISC   = 2'd2,
        KIND_DONE   = 2'd3
    } t_kind;

    // index of the polled_mode register
    localparam logic REG_POLLED_MODE = 1'b0;

    typedef struct packed {
        logic                aux_done_flag;
        logic                disc_done_flag;
        logic [SIZE_W-1:0]   bytes_to_aux;
        logic [SIZE_W-1:0]   bytes_to_read;
        logic [OFF_W-1:0]    aux_write_pos;
        logic [OFF_W-1:0]    disc_read_pos;
        logic                active_buffer;
        logic                load_finished;
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic                buffer_sel;
        logic [OFF_W-1:0]    aux_offset;
        logic [OFF_W-1:0]    disc_offset;
        logic [LEN_W-1:0]    chunk_len;
        logic                loaded;
        logic                last;
    } t_result;

    // bytes of the next chunk out of n remaining
    function automatic logic [SIZE_W-1:0] chunk_of(input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] lim;
        lim = SIZE_W'(CHUNK_BYTES);
        return (n < lim) ? n : lim;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ping_pong_chunk_transfer_sequencer.sv @@
// top level of the ping-pong chunk transfer sequencer
`default_nettype none

// Sequences the copy of one file from disc into aux memory through two staging
// buffers used in turn, in chunks of up to CHUNK_BYTES. A start transfer issues
// the first disc read into buffer 0; disc-done and aux-done transfers set their
// flags and, once both are set (by the later of the two when polled_mode is 0,
// on a poll when polled_mode is 1), the block issues an aux request from the
// active buffer, flips buffers and issues the next disc read while bytes remain,
// or reports load complete. Each input transfer yields one or two output
// transfers, written into the result queue on acceptance and shown in order.
// An input transfer is taken every cycle while the result queue (4 entries)
// holds at most two results; the output port moves one result per cycle while
// m_axis_tready is high, so two-result items or a stalled output hold the input.

module ping_pong_chunk_transfer_sequencer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [pptcs_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // file_size[24:0]
    input  wire logic [pptcs_pkg::CMD_W-1:0]        s_axis_tuser,   // cmd[1:0]

    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // buffer_sel[0], aux_offset[24:1], disc_offset[48:25], chunk_len[65:49],
    // loaded[66], zero fill[71:67]
    output logic [pptcs_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    output logic [pptcs_pkg::KIND_W-1:0]            m_axis_tuser,   // kind[1:0]
    output logic                                    m_axis_tlast,

    // register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pptcs_pkg::APB_AW-1:0]       paddr,
    input  wire logic [pptcs_pkg::APB_DW-1:0]       pwdata,
    output logic [pptcs_pkg::APB_DW-1:0]            prdata,
    output logic                                    pready
);

    localparam pptcs_pkg::t_state STATE_RESET = '{
        aux_done_flag:  1'b1,
        disc_done_flag: 1'b0,
        bytes_to_aux:   '0,
        bytes_to_read:  '0,
        aux_write_pos:  '0,
        disc_read_pos:  '0,
        active_buffer:  1'b0,
        load_finished:  1'b0
    };

    pptcs_pkg::t_state      r_state;
    pptcs_pkg::t_state      n_state;
    logic                   r_polled_mode;
    pptcs_pkg::t_result     w_res0;
    pptcs_pkg::t_result     w_res1;
    pptcs_pkg::t_result     w_head;
    logic                   w_two;
    logic                   w_room;
    logic                   w_in_xfer;
    logic                   w_cfg_wr;
    logic                   w_reg_sel;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    // register index sits above the word offset
    assign w_reg_sel = (paddr[pptcs_pkg::APB_AW-1] == pptcs_pkg::REG_POLLED_MODE);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polled_mode <= 1'b0;
        end else if (w_cfg_wr && w_reg_sel) begin
            r_polled_mode <= pwdata[0];
        end
    end

    assign prdata = w_reg_sel ? {{(pptcs_pkg::APB_DW-1){1'b0}}, r_polled_mode} : '0;

    // ---------------- sequencing state ----------------
    assign s_axis_tready = w_room;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    pptcs_step u_step (
        .i_state       (r_state),
        .i_polled_mode (r_polled_mode),
        .i_cmd         (pptcs_pkg::t_cmd'(s_axis_tuser)),
        .i_file_size   (s_axis_tdata[pptcs_pkg::SIZE_W-1:0]),
        .o_state       (n_state),
        .o_res0        (w_res0),
        .o_res1        (w_res1),
        .o_two         (w_two)
    );

    // state moves only on an accepted input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_in_xfer) begin
            r_state <= n_state;
        end
    end

    // ---------------- result queue ----------------
    pptcs_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_in_xfer),
        .i_push_two (w_two),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .i_pop      (m_axis_tready),
        .o_head     (w_head),
        .o_valid    (m_axis_tvalid),
        .o_room     (w_room)
    );

    assign m_axis_tdata = {
        {(pptcs_pkg::M_TDATA_W - 67){1'b0}},
        w_head.loaded,
        w_head.chunk_len,
        w_head.disc_offset,
        w_head.aux_offset,
        w_head.buffer_sel
    };
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

endmodule

`default_nettype wire

@@ hw/rtl/pptcs_step.sv @@
// next-state and result logic for one input item
`default_nettype none

module pptcs_step (
    input  wire pptcs_pkg::t_state              i_state,
    input  wire logic                           i_polled_mode,
    input  wire pptcs_pkg::t_cmd                i_cmd,
    input  wire logic [pptcs_pkg::SIZE_W-1:0]   i_file_size,
    output pptcs_pkg::t_state                   o_state,
    output pptcs_pkg::t_result                  o_res0,
    output pptcs_pkg::t_result                  o_res1,
    output logic                                o_two
);

    logic [pptcs_pkg::SIZE_W-1:0] w_size;
    logic [pptcs_pkg::SIZE_W-1:0] w_len_start;
    logic [pptcs_pkg::SIZE_W-1:0] w_len_aux;
    logic [pptcs_pkg::SIZE_W-1:0] w_len_disc;
    logic                         w_step;

    // oversized files saturate
    assign w_size = (i_file_size > pptcs_pkg::SIZE_W'(pptcs_pkg::MAX_FILE))
                  ? pptcs_pkg::SIZE_W'(pptcs_pkg::MAX_FILE) : i_file_size;
    assign w_len_start = pptcs_pkg::chunk_of(w_size);
    assign w_len_aux   = pptcs_pkg::chunk_of(i_state.bytes_to_aux);
    assign w_len_disc  = pptcs_pkg::chunk_of(i_state.bytes_to_read);

    always_comb begin
        o_state = i_state;
        w_step  = 1'b0;
        o_two   = 1'b0;
        o_res0  = '0;
        o_res1  = '0;
        o_res0.kind       = pptcs_pkg::KIND_STATUS;
        o_res0.buffer_sel = i_state.active_buffer;
        o_res1.kind       = pptcs_pkg::KIND_DISC;

        case (i_cmd)
            pptcs_pkg::CMD_START: begin
                o_state.aux_done_flag  = 1'b1;
                o_state.disc_done_flag = 1'b0;
                o_state.bytes_to_aux   = w_size;
                o_state.bytes_to_read  = w_size - w_len_start;
                o_state.aux_write_pos  = '0;
                o_state.disc_read_pos  = w_len_start[pptcs_pkg::OFF_W-1:0];
                o_state.active_buffer  = 1'b0;
                o_state.load_finished  = 1'b0;
                o_res0.kind            = pptcs_pkg::KIND_DISC;
                o_res0.buffer_sel      = 1'b0;
                o_res0.chunk_len       = w_len_start[pptcs_pkg::LEN_W-1:0];
            end
            pptcs_pkg::CMD_DISC_DONE: begin
                o_state.disc_done_flag = 1'b1;
                w_step = !i_polled_mode && i_state.aux_done_flag;
            end
            pptcs_pkg::CMD_AUX_DONE: begin
                o_state.aux_done_flag = 1'b1;
                w_step = !i_polled_mode && i_state.disc_done_flag;
            end
            pptcs_pkg::CMD_POLL: begin
                w_step = !i_state.load_finished && i_polled_mode
                      && i_state.aux_done_flag && i_state.disc_done_flag;
            end
            default: begin
                w_step = 1'b0;
            end
        endcase

        if (w_step) begin
            if (i_state.bytes_to_aux == '0) begin
                // nothing left for aux memory
                o_state.load_finished = 1'b1;
                o_res0.kind           = pptcs_pkg::KIND_DONE;
            end else begin
                o_res0.kind           = pptcs_pkg::KIND_AUX;
                o_res0.aux_offset     = i_state.aux_write_pos;
                o_res0.chunk_len      = w_len_aux[pptcs_pkg::LEN_W-1:0];
                o_state.bytes_to_aux  = i_state.bytes_to_aux - w_len_aux;
                o_state.aux_write_pos = i_state.aux_write_pos
                                      + w_len_aux[pptcs_pkg::OFF_W-1:0];
                o_state.aux_done_flag = 1'b0;
                o_state.active_buffer = !i_state.active_buffer;
                if (i_state.bytes_to_read != '0) begin
                    // refill the buffer just freed
                    o_two                  = 1'b1;
                    o_state.disc_done_flag = 1'b0;
                    o_res1.buffer_sel      = !i_state.active_buffer;
                    o_res1.disc_offset     = i_state.disc_read_pos;
                    o_res1.chunk_len       = w_len_disc[pptcs_pkg::LEN_W-1:0];
                    o_state.disc_read_pos  = i_state.disc_read_pos
                                           + w_len_disc[pptcs_pkg::OFF_W-1:0];
                    o_state.bytes_to_read  = i_state.bytes_to_read - w_len_disc;
                end
            end
        end

        o_res0.loaded = o_state.load_finished;
        o_res1.loaded = o_state.load_finished;
        o_res0.last   = !o_two;
        o_res1.last   = 1'b1;
    end

endmodule

`default_nettype wire

@@ hw/rtl/pptcs_fifo.sv @@
// small result queue taking one or two results per cycle and giving one
`default_nettype none

module pptcs_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire logic                   i_push_two,
    input  wire pptcs_pkg::t_result     i_res0,
    input  wire pptcs_pkg::t_result     i_res1,
    input  wire logic                   i_pop,
    output pptcs_pkg::t_result          o_head,
    output logic                        o_valid,
    output logic                        o_room
);

    pptcs_pkg::t_result                 r_mem [pptcs_pkg::QDEPTH];
    logic [pptcs_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [pptcs_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [pptcs_pkg::QCNT_W-1:0]       r_count;
    logic [pptcs_pkg::QPTR_W-1:0]       n_wr_ptr;
    logic [pptcs_pkg::QCNT_W-1:0]       n_count;
    logic [pptcs_pkg::QPTR_W-1:0]       w_wr_next;
    logic                               w_pop;

    assign w_wr_next = r_wr_ptr + pptcs_pkg::QPTR_W'(1);
    assign w_pop     = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = i_push_two ? (r_wr_ptr + pptcs_pkg::QPTR_W'(2)) : w_wr_next;
            n_count  = r_count + (i_push_two ? pptcs_pkg::QCNT_W'(2)
                                             : pptcs_pkg::QCNT_W'(1));
        end
        if (w_pop) begin
            n_count = n_count - pptcs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + pptcs_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res0;
            if (i_push_two) begin
                r_mem[w_wr_next] <= i_res1;
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    // space for the two results an item may bring
    assign o_room  = (r_count <= pptcs_pkg::QCNT_W'(pptcs_pkg::QDEPTH - 2));

endmodule

`default_nettype wire

@@ hw/rtl/pptcs_checker.sv @@
// port-level checks for the ping-pong chunk transfer sequencer
`default_nettype none

module pptcs_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [pptcs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic [pptcs_pkg::KIND_W-1:0]       m_axis_tuser,
    input  wire logic                               m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !m_axis_tvalid)
        else $error("result shown right after reset");

    // an aux request that is not last is followed at once by its disc read
    a_aux_then_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        && (m_axis_tuser == pptcs_pkg::KIND_AUX)
        |=> m_axis_tvalid && (m_axis_tuser == pptcs_pkg::KIND_DISC) && m_axis_tlast)
        else $error("aux request not followed by disc read");

    // completion always reports loaded
    a_done_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == pptcs_pkg::KIND_DONE)
        |-> m_axis_tdata[66] && m_axis_tlast)
        else $error("completion without loaded");

    // status and completion move no bytes
    a_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tuser == pptcs_pkg::KIND_DONE)
                       || (m_axis_tuser == pptcs_pkg::KIND_STATUS))
        |-> (m_axis_tdata[65:49] == '0) && (m_axis_tdata[48:1] == '0))
        else $error("status result carries a transfer");

endmodule

bind ping_pong_chunk_transfer_sequencer pptcs_checker u_pptcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
